// ----- rtl/binary_min_heap_queue_macros.svh -----
// Assertion macros shared by the heap queue RTL.
`ifndef BINARY_MIN_HEAP_QUEUE_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define BMHQ_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BMHQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define BMHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bmhq_pkg.sv -----
// Types and constants of the binary min heap queue.
package bmhq_pkg;

  localparam int HEAP_SLOTS_DEF = 16;
  localparam int OP_W           = 2;
  localparam int KEY_W          = 32;
  localparam int PAY_W          = 32;
  localparam int STATUS_W       = 2;
  localparam int COUNT_W        = 4;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic signed [KEY_W-1:0] item_key;
    logic [PAY_W-1:0]        item_payload;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAY_W-1:0]    out_payload;
    logic [COUNT_W-1:0]  entry_count_out;
  } result_t;

  // One heap slot as stored in memory
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- rtl/bmhq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bmhq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bmhq_ctrl.sv -----
// Heap sequencer: decodes operations and walks sift up and sift down over the RAM.
`include "binary_min_heap_queue_macros.svh"

module bmhq_ctrl #(
  parameter int HEAP_SLOTS = bmhq_pkg::HEAP_SLOTS_DEF,
  parameter int AW         = $clog2(HEAP_SLOTS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  bmhq_pkg::item_t   item,
  output logic              busy,
  output logic              done,
  input  logic              take,
  output bmhq_pkg::result_t res,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [bmhq_pkg::ENTRY_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  input  logic [bmhq_pkg::ENTRY_W-1:0] mem_rdata
);

  import bmhq_pkg::*;

  localparam int CW = (AW > COUNT_W) ? AW : COUNT_W;
  localparam logic [AW-1:0] CNT_FULL = AW'(HEAP_SLOTS - 1);
  localparam logic [AW-1:0] ROOT     = AW'(1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_UP_RD  = 4'd1;
  localparam logic [3:0] S_UP_CMP = 4'd2;
  localparam logic [3:0] S_ROOT   = 4'd3;
  localparam logic [3:0] S_LAST   = 4'd4;
  localparam logic [3:0] S_DN_L   = 4'd5;
  localparam logic [3:0] S_DN_R   = 4'd6;
  localparam logic [3:0] S_DN_CMP = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]          state, state_next;
  logic [AW-1:0]       cnt, cnt_next;
  logic [AW-1:0]       pos, pos_next;
  logic [OP_W-1:0]     op, op_next;
  entry_t              hold, hold_next;
  entry_t              left, left_next;
  logic                has_right, has_right_next;
  logic [STATUS_W-1:0] status, status_next;
  logic [PAY_W-1:0]    pay, pay_next;

  entry_t        rd;
  entry_t        least;
  logic [AW-1:0] up;
  logic [AW:0]   lo, hi;
  logic          use_right;
  logic [CW-1:0] cnt_wide;

  assign rd        = entry_t'(mem_rdata);
  assign up        = pos >> 1;
  assign lo        = {pos, 1'b0};
  assign hi        = {pos, 1'b1};
  assign use_right = has_right && (rd.key < left.key);
  assign least     = use_right ? rd : left;

  // Sequence one operation; reads and writes never share a cycle
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    pos_next       = pos;
    op_next        = op;
    hold_next      = hold;
    left_next      = left;
    has_right_next = has_right;
    status_next    = status;
    pay_next       = pay;
    mem_we         = 1'b0;
    mem_waddr      = pos;
    mem_wdata      = hold;
    mem_re         = 1'b0;
    mem_raddr      = ROOT;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          op_next     = item.opcode;
          hold_next   = '{key: item.item_key, payload: item.item_payload};
          status_next = ST_OK;
          pay_next    = '0;
          unique case (item.opcode)
            OP_INSERT: begin
              if (cnt == CNT_FULL) begin
                status_next = ST_FULL;
                state_next  = S_DONE;
              end else begin
                cnt_next   = cnt + 1'b1;
                pos_next   = cnt + 1'b1;
                state_next = S_UP_RD;
              end
            end
            OP_REMOVE, OP_PEEK: begin
              if (cnt == '0) begin
                status_next = ST_EMPTY;
                state_next  = S_DONE;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = ROOT;
                state_next = S_ROOT;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_UP_RD: begin
        if (up == '0) begin
          mem_we     = 1'b1;
          mem_wdata  = hold;
          state_next = S_DONE;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = up;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (hold.key < rd.key) begin
          mem_wdata  = rd;
          pos_next   = up;
          state_next = S_UP_RD;
        end else begin
          mem_wdata  = hold;
          state_next = S_DONE;
        end
      end
      S_ROOT: begin
        pay_next = rd.payload;
        if (op == OP_PEEK) begin
          state_next = S_DONE;
        end else begin
          cnt_next = cnt - 1'b1;
          if (cnt == ROOT) begin
            state_next = S_DONE;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = cnt;
            state_next = S_LAST;
          end
        end
      end
      S_LAST: begin
        hold_next  = rd;
        pos_next   = ROOT;
        state_next = S_DN_L;
      end
      S_DN_L: begin
        if (lo > {1'b0, cnt}) begin
          mem_we     = 1'b1;
          mem_wdata  = hold;
          state_next = S_DONE;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = lo[AW-1:0];
          state_next = S_DN_R;
        end
      end
      S_DN_R: begin
        left_next  = rd;
        state_next = S_DN_CMP;
        if (hi <= {1'b0, cnt}) begin
          mem_re         = 1'b1;
          mem_raddr      = hi[AW-1:0];
          has_right_next = 1'b1;
        end else begin
          has_right_next = 1'b0;
        end
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (least.key < hold.key) begin
          mem_wdata  = least;
          pos_next   = use_right ? hi[AW-1:0] : lo[AW-1:0];
          state_next = S_DN_L;
        end else begin
          mem_wdata  = hold;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    pos       <= pos_next;
    op        <= op_next;
    hold      <= hold_next;
    left      <= left_next;
    has_right <= has_right_next;
    status    <= status_next;
    pay       <= pay_next;
  end

  // Present the finished result
  assign cnt_wide            = CW'(cnt);
  assign busy                = (state != S_IDLE);
  assign done                = (state == S_DONE);
  assign res.status          = status;
  assign res.out_payload     = pay;
  assign res.entry_count_out = cnt_wide[COUNT_W-1:0];

  `BMHQ_ASSERT(a_cnt_range, cnt <= CNT_FULL, "entry count beyond capacity")
  `BMHQ_ASSERT_IMPL(a_no_slot0, mem_we || mem_re, (mem_we ? mem_waddr : mem_raddr) != '0, "slot zero accessed")
  `BMHQ_ASSERT_IMPL(a_one_access, mem_re, !mem_we, "read and write in one cycle")
  `BMHQ_ASSERT_NEXT(a_accept_busy, item_valid && !busy, busy, "accepted item did not start")

endmodule

// ----- rtl/binary_min_heap_queue.sv -----
// Top level of the binary min heap priority queue.
//
//   channel | direction | handshake                  | payload
//   item    | in        | item_valid / item_stall    | bmhq_pkg::item_t
//   result  | out       | result_valid / result_stall| bmhq_pkg::result_t
//
// Insert moves the new entry up until the root or a compare stops it; remove
// moves the last entry to the root and down until a leaf or a compare stops
// it; peek and removal of the last entry read only the root; rejected, empty
// and no-op items skip the RAM. RAM reads and writes take turns, setting the pace.
// Reset (rst, synchronous) empties the heap at once; no clearing pass.
// One result may wait under result_stall while the next item runs; a second
// finished result holds item_stall high until the first drains.
`include "binary_min_heap_queue_macros.svh"

module binary_min_heap_queue #(
  parameter int HEAP_SLOTS = bmhq_pkg::HEAP_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  bmhq_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output bmhq_pkg::result_t result
);

  import bmhq_pkg::*;

  localparam int AW = $clog2(HEAP_SLOTS);

  logic                busy;
  logic                done;
  logic                take;
  result_t             res;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [ENTRY_W-1:0]  mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [ENTRY_W-1:0]  mem_rdata;

  bmhq_ctrl #(
    .HEAP_SLOTS (HEAP_SLOTS),
    .AW         (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .busy       (busy),
    .done       (done),
    .take       (take),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  bmhq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HEAP_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign item_stall = busy;

  // Load the output register when it is empty or being drained
  assign take = done && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= res;
    end
  end

  `BMHQ_ASSERT_NEXT(a_take_shows, take, result_valid, "taken result not presented")
  `BMHQ_ASSERT_IMPL(a_done_busy, done, busy, "result pending while idle")
  `BMHQ_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

endmodule
